// ===== src/tsc_pkg.sv =====
package tsc_pkg;

   localparam int ByteW    = 8;
   localparam int TempW    = 19;
   localparam int StatusW  = 3;
   localparam int IdxW     = 4;
   localparam int ResW     = 2;
   localparam int CsrIdxW  = 3;
   localparam int RawW     = 16;
   localparam int ProdW    = 23;
   localparam int RspDataW = 24;

   // byte positions within one scratchpad reading
   localparam logic [IdxW-1:0] IDX_RAW_LOW  = IdxW'(0);
   localparam logic [IdxW-1:0] IDX_RAW_HIGH = IdxW'(1);
   localparam logic [IdxW-1:0] IDX_ALARM_A  = IdxW'(2);
   localparam logic [IdxW-1:0] IDX_ALARM_B  = IdxW'(3);
   localparam logic [IdxW-1:0] IDX_CONFIG   = IdxW'(4);
   localparam logic [IdxW-1:0] IDX_DECODE   = IdxW'(5);
   localparam logic [IdxW-1:0] IDX_DIFF     = IdxW'(6);
   localparam logic [IdxW-1:0] IDX_CRC      = IdxW'(8);

   localparam logic [StatusW-1:0] ST_OK        = StatusW'(0);
   localparam logic [StatusW-1:0] ST_NOT_CONV  = StatusW'(1);
   localparam logic [StatusW-1:0] ST_CRC_ERR   = StatusW'(2);
   localparam logic [StatusW-1:0] ST_ABOVE_MAX = StatusW'(3);
   localparam logic [StatusW-1:0] ST_BELOW_MIN = StatusW'(4);
   localparam logic [StatusW-1:0] ST_DELTA     = StatusW'(5);

   localparam logic [CsrIdxW-1:0] CSR_MAX_ENABLE = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_TEMP_MAX   = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CSR_MIN_ENABLE = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] CSR_TEMP_MIN   = CsrIdxW'(3);
   localparam logic [CsrIdxW-1:0] CSR_DELTA_MAX  = CsrIdxW'(4);

   localparam logic [ResW-1:0] RES_9BIT  = ResW'(0);
   localparam logic [ResW-1:0] RES_10BIT = ResW'(1);
   localparam logic [ResW-1:0] RES_11BIT = ResW'(2);

   localparam logic [ByteW-1:0] CRC_POLY = 8'h8C;

   typedef logic signed [TempW-1:0] temp_type;

   // reflected crc-8, one byte
   function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
      logic [ByteW-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < ByteW; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/tsc_temp_decode.sv =====
module tsc_temp_decode
   import tsc_pkg::*;
(
   input  logic [ByteW-1:0] raw_low,
   input  logic [ByteW-1:0] raw_high,
   input  logic [ResW-1:0]  res_code,
   output temp_type         temp_centi
);

   logic [RawW-1:0]         raw_masked;
   logic signed [RawW-1:0]  raw_s;
   logic signed [ProdW-1:0] prod;
   logic signed [ProdW-1:0] biased;

   always_comb begin
      case (res_code)
         RES_9BIT:  raw_masked = {raw_high, raw_low} & 16'hFFF8;
         RES_10BIT: raw_masked = {raw_high, raw_low} & 16'hFFFC;
         RES_11BIT: raw_masked = {raw_high, raw_low} & 16'hFFFE;
         default:   raw_masked = {raw_high, raw_low};
      endcase
   end

   assign raw_s = signed'(raw_masked);
   assign prod  = ProdW'(raw_s) * ProdW'(100);

   // divide by 16 rounding toward zero
   assign biased     = prod + (prod[ProdW-1] ? ProdW'(15) : ProdW'(0));
   assign temp_centi = signed'(biased[ProdW-1:4]);

endmodule

// ===== src/temp_scratchpad_checker_top.sv =====
// Checks the nine-byte scratchpad of a 1-Wire temperature sensor. Bytes enter one per
// req transaction, byte 0 first, and the block takes one byte every clock cycle. After
// the ninth byte one rsp transaction follows on the next cycle with a status code and
// the stored temperature in hundredths of a degree: not converted when byte 2 or 3 is
// nonzero, then crc error, else the decoded value is stored and tested against the
// enabled upper and lower limits and the largest allowed change from the last stored
// value (skipped if zero or none stored yet). The only stall comes from the result
// register: while a result waits on rsp_tready, req_tready stays low. The temperature
// is decoded after byte 4 and its change computed after byte 5, so the ninth byte only
// sees a crc compare and three limit compares. Configuration writes are taken in any
// cycle; write them only between readings or before a reading's last byte.
module temp_scratchpad_checker_top
   import tsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] scratch_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [2:0] status, [21:3] temp_centi
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [TempW-1:0]    csr_data
);

   logic req_fire;
   logic csr_fire;

   logic [IdxW-1:0]    idx_ff, idx_in;
   logic [ByteW-1:0]   crc_ff, crc_in;
   logic [ByteW-1:0]   raw_low_ff, raw_low_in;
   logic [ByteW-1:0]   raw_high_ff, raw_high_in;
   logic               alarm_ff, alarm_in;
   logic [ResW-1:0]    res_ff, res_in;
   temp_type           dec_temp_ff, dec_temp_in;
   logic [TempW-1:0]   diff_ff, diff_in;
   temp_type           last_temp_ff, last_temp_in;
   logic               last_valid_ff, last_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;
   temp_type           rsp_temp_ff, rsp_temp_in;

   logic               max_en_ff, max_en_in;
   temp_type           temp_max_ff, temp_max_in;
   logic               min_en_ff, min_en_in;
   temp_type           temp_min_ff, temp_min_in;
   logic [TempW-1:0]   delta_max_ff, delta_max_in;

   temp_type           dec_temp;
   logic signed [TempW:0] delta_s;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_temp_ff, rsp_status_ff};

   tsc_temp_decode u_decode (
      .raw_low    (raw_low_ff),
      .raw_high   (raw_high_ff),
      .res_code   (res_ff),
      .temp_centi (dec_temp)
   );

   assign delta_s = (TempW+1)'(dec_temp_ff) - (TempW+1)'(last_temp_ff);

   always_comb begin
      max_en_in    = max_en_ff;
      temp_max_in  = temp_max_ff;
      min_en_in    = min_en_ff;
      temp_min_in  = temp_min_ff;
      delta_max_in = delta_max_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_MAX_ENABLE: max_en_in    = csr_data[0];
            CSR_TEMP_MAX:   temp_max_in  = signed'(csr_data);
            CSR_MIN_ENABLE: min_en_in    = csr_data[0];
            CSR_TEMP_MIN:   temp_min_in  = signed'(csr_data);
            CSR_DELTA_MAX:  delta_max_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in        = idx_ff;
      crc_in        = crc_ff;
      raw_low_in    = raw_low_ff;
      raw_high_in   = raw_high_ff;
      alarm_in      = alarm_ff;
      res_in        = res_ff;
      dec_temp_in   = dec_temp_ff;
      diff_in       = diff_ff;
      last_temp_in  = last_temp_ff;
      last_valid_in = last_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_temp_in   = rsp_temp_ff;

      if (req_fire) begin
         if (idx_ff == IDX_CRC) begin
            idx_in       = IDX_RAW_LOW;
            rsp_valid_in = 1'b1;
            if (alarm_ff) begin
               rsp_status_in = ST_NOT_CONV;
            end else if (crc_ff != req_tdata) begin
               rsp_status_in = ST_CRC_ERR;
            end else begin
               if (max_en_ff && dec_temp_ff > temp_max_ff) begin
                  rsp_status_in = ST_ABOVE_MAX;
               end else if (min_en_ff && dec_temp_ff < temp_min_ff) begin
                  rsp_status_in = ST_BELOW_MIN;
               end else if (delta_max_ff != '0 && last_valid_ff && diff_ff > delta_max_ff) begin
                  rsp_status_in = ST_DELTA;
               end else begin
                  rsp_status_in = ST_OK;
               end
               last_temp_in  = dec_temp_ff;
               last_valid_in = 1'b1;
            end
            rsp_temp_in = last_temp_in;
         end else begin
            idx_in = idx_ff + IdxW'(1);
            crc_in = crc8_byte((idx_ff == IDX_RAW_LOW) ? '0 : crc_ff, req_tdata);
            case (idx_ff) inside
               IDX_RAW_LOW: begin
                  raw_low_in = req_tdata;
                  alarm_in   = 1'b0;
               end
               IDX_RAW_HIGH: raw_high_in = req_tdata;
               IDX_ALARM_A, IDX_ALARM_B: alarm_in = alarm_ff || (req_tdata != '0);
               IDX_CONFIG: res_in = req_tdata[6:5];
               IDX_DECODE: dec_temp_in = dec_temp;
               IDX_DIFF: diff_in = delta_s[TempW] ? TempW'(-delta_s) : delta_s[TempW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= IDX_RAW_LOW;
         last_temp_ff  <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_en_ff     <= 1'b0;
         temp_max_ff   <= '0;
         min_en_ff     <= 1'b0;
         temp_min_ff   <= '0;
         delta_max_ff  <= '0;
      end else begin
         idx_ff        <= idx_in;
         last_temp_ff  <= last_temp_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_en_ff     <= max_en_in;
         temp_max_ff   <= temp_max_in;
         min_en_ff     <= min_en_in;
         temp_min_ff   <= temp_min_in;
         delta_max_ff  <= delta_max_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff        <= crc_in;
      raw_low_ff    <= raw_low_in;
      raw_high_ff   <= raw_high_in;
      alarm_ff      <= alarm_in;
      res_ff        <= res_in;
      dec_temp_ff   <= dec_temp_in;
      diff_ff       <= diff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_temp_ff   <= rsp_temp_in;
   end

   // a result only appears right after the ninth byte of a reading
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(req_fire && idx_ff == IDX_CRC))
      else $error("result without a last byte");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_CRC)
      else $error("byte position out of range");

   a_last_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(last_valid_ff))
      else $error("stored temperature lost its valid mark");

   // a bad reading leaves the stored temperature alone
   a_bad_keeps_temp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && idx_ff == IDX_CRC && (alarm_ff || crc_ff != req_tdata))
      |=> $stable(last_temp_ff))
      else $error("stored temperature changed on a rejected reading");

endmodule
